// ===== rtl/gcm_pkg.sv =====
// Shared types and constants for the greedy change maker.
`timescale 1ns / 1ps
`default_nettype none

package gcm_pkg;

  // Stream word widths (whole bytes)
  localparam int S_DATA_W = 64;  // pay_amount, coin_value
  localparam int M_DATA_W = 72;  // coin_out, coin_count, solved, padding
  localparam int FIELD_W  = 32;

  // Input word kind (s_tuser)
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_COIN  = 1'b1;

  // Output word kind (m_tuser)
  localparam logic KIND_COUNT  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_CNT  = 4'b0100,
    ST_STAT = 4'b1000
  } gcm_state_t;

endpackage

`default_nettype wire

// ===== rtl/greedy_change_maker_top.sv =====
// Greedy change maker: bit-serial divider with count and status output stage.
//
//  channel | dir | tdata                         | tuser | tlast
//  --------+-----+-------------------------------+-------+-----------
//  s_*     | in  | pay_amount, coin_value        | mode  | final_item
//  m_*     | out | coin_out, coin_count, solved  | kind  | end_of_run
//
// A start word, or a denomination that gives no count, is taken without division.
// A denomination that divides runs through the restoring divider (one
// quotient bit per cycle) and then loads the count into the output
// register; a final word adds the status word. rst is synchronous and
// clears the sequencer and amount state.
// A stalled output only holds the sequencer when a new result must be loaded.
`timescale 1ns / 1ps
`default_nettype none

module greedy_change_maker_top #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // slave side
  input  wire logic                         s_tvalid,
  output      logic                         s_tready,
  input  wire logic [gcm_pkg::S_DATA_W-1:0] s_tdata,   // [31:0] pay_amount, [63:32] coin_value
  input  wire logic                         s_tuser,   // [0] mode
  input  wire logic                         s_tlast,
  // master side
  output      logic                         m_tvalid,
  input  wire logic                         m_tready,
  output      logic [gcm_pkg::M_DATA_W-1:0] m_tdata,   // [31:0] coin_out, [63:32] coin_count,
                                                       // [64] solved, [71:65] zero
  output      logic                         m_tuser,   // [0] kind
  output      logic                         m_tlast
);

  import gcm_pkg::*;

  localparam int W     = VALUE_WIDTH;
  localparam int CNT_W = $clog2(W);

  gcm_state_t state;

  // transaction state
  logic [W-1:0] remaining;
  logic         amount_valid;
  logic         saw_coin;
  logic         pend_final;

  // divider registers
  logic [W-1:0]     divisor;
  logic [W-1:0]     quo;
  logic [W-1:0]     rem;
  logic [CNT_W-1:0] bit_cnt;

  logic         in_acc;
  logic         out_free;
  logic         out_load;
  logic [63:0]  amt_wide;
  logic [63:0]  coin_wide;
  logic [W-1:0] amt;
  logic [W-1:0] coin;
  logic [W:0]   shifted;
  logic [W:0]   diff;
  logic         ge;
  logic [W-1:0] rem_next;
  logic [W-1:0] quo_next;
  logic [63:0]  quo_wide;
  logic [63:0]  div_wide;
  logic         solved;

  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign out_load = out_free && ((state == ST_CNT) || (state == ST_STAT));
  assign s_tready = (state == ST_IDLE);

  // input fields held at VALUE_WIDTH bits
  assign amt_wide  = {32'd0, s_tdata[FIELD_W-1:0]};
  assign coin_wide = {32'd0, s_tdata[2*FIELD_W-1:FIELD_W]};
  assign amt       = amt_wide[W-1:0];
  assign coin      = coin_wide[W-1:0];

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign shifted  = {rem, quo[W-1]};
  assign diff     = shifted - {1'b0, divisor};
  assign ge       = (shifted >= {1'b0, divisor});
  assign rem_next = ge ? diff[W-1:0] : shifted[W-1:0];
  assign quo_next = {quo[W-2:0], ge};

  assign quo_wide = 64'(quo);
  assign div_wide = 64'(divisor);
  assign solved   = amount_valid && saw_coin && (remaining == '0);

  // sequencer and transaction state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      m_tvalid     <= 1'b0;
      remaining    <= '0;
      amount_valid <= 1'b0;
      saw_coin     <= 1'b0;
      pend_final   <= 1'b0;
    end else begin
      // output valid: set on load, cleared once taken
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            pend_final <= s_tlast;
            if (s_tuser == MODE_START) begin
              remaining    <= amt;
              amount_valid <= (amt != '0);
              saw_coin     <= 1'b0;
              if (s_tlast) begin
                state <= ST_STAT;
              end
            end else begin
              saw_coin <= 1'b1;
              if ((coin != '0) && (remaining >= coin)) begin
                state <= ST_DIV;
              end else if (s_tlast) begin
                state <= ST_STAT;
              end
            end
          end
        end
        ST_DIV: begin
          if (bit_cnt == '0) begin
            remaining <= rem_next;
            state     <= ST_CNT;
          end
        end
        ST_CNT: begin
          if (out_free) begin
            state <= pend_final ? ST_STAT : ST_IDLE;
          end
        end
        ST_STAT: begin
          if (out_free) begin
            remaining    <= '0;
            amount_valid <= 1'b0;
            saw_coin     <= 1'b0;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // divider shift registers and output word
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          divisor <= coin;
          quo     <= remaining;
          rem     <= '0;
          bit_cnt <= CNT_W'(W - 1);
        end
      end
      ST_DIV: begin
        quo     <= quo_next;
        rem     <= rem_next;
        bit_cnt <= bit_cnt - 1'b1;
      end
      ST_CNT: begin
        if (out_free) begin
          m_tdata <= {7'd0, 1'b0, quo_wide[FIELD_W-1:0], div_wide[FIELD_W-1:0]};
          m_tuser <= KIND_COUNT;
          m_tlast <= 1'b0;
        end
      end
      ST_STAT: begin
        if (out_free) begin
          m_tdata <= {7'd0, solved, 64'd0};
          m_tuser <= KIND_STATUS;
          m_tlast <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
